// ===== rtl/button_debounce_long_press_core_assert.svh =====
// Assertion macros for the button debounce core.
// Used by the top-level RTL file, which checks its own control invariants; needs a clock and reset in scope.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_CORE_ASSERT_SVH

// expression must hold at every edge outside reset
`define BDLP_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BDLP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bdlp_pkg.sv =====
// Package for the button debounce / long press core.
// Shared types, reset constants and the countdown load helper; no dependencies.
`default_nettype none

package bdlp_pkg;

   localparam int CNT_W     = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TICKS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_TICKS = 2'd1;

   localparam logic [CNT_W-1:0] DEBOUNCE_TICKS_RESET   = 16'd20;
   localparam logic [CNT_W-1:0] LONG_PRESS_TICKS_RESET = 16'd1000;

   typedef struct packed {
      logic [CNT_W-1:0] debounce_ticks;
      logic [CNT_W-1:0] long_press_ticks;
   } cfg_type;

   typedef struct packed {
      logic             previous_raw;
      logic [CNT_W-1:0] debounce_left;
      logic             debounce_armed;
      logic             held_state;
      logic             long_done;
      logic [CNT_W-1:0] long_left;
      logic             long_armed;
   } state_type;

   typedef struct packed {
      logic event_valid;
      logic event_is_long;
      logic button_held;
   } result_type;

   // a zero setting still counts one tick
   function automatic logic [CNT_W-1:0] load_value(input logic [CNT_W-1:0] reg_value);
      return (reg_value == '0) ? CNT_W'(1) : reg_value;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/bdlp_csr.sv =====
// Configuration registers of the button debounce core.
// Uses bdlp_pkg for register indexes, reset values and the cfg_type struct.
`default_nettype none

module bdlp_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_en,
   input  wire logic [bdlp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bdlp_pkg::CNT_W-1:0]     csr_wdata,
   output bdlp_pkg::cfg_type                   cfg
);

   bdlp_pkg::cfg_type cfg_ff;
   bdlp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            bdlp_pkg::CSR_DEBOUNCE_TICKS:   cfg_in.debounce_ticks   = csr_wdata;
            bdlp_pkg::CSR_LONG_PRESS_TICKS: cfg_in.long_press_ticks = csr_wdata;
            default:                        cfg_in = cfg_ff; // unmapped index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= bdlp_pkg::DEBOUNCE_TICKS_RESET;
         cfg_ff.long_press_ticks <= bdlp_pkg::LONG_PRESS_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/bdlp_step.sv =====
// One-tick update of the debounce and long press state.
// Pure combinational; uses bdlp_pkg types and load_value.
`default_nettype none

module bdlp_step (
   input  wire logic                  level,
   input  wire bdlp_pkg::cfg_type     cfg,
   input  wire bdlp_pkg::state_type   state_cur,
   output bdlp_pkg::state_type        state_nxt,
   output bdlp_pkg::result_type       result
);

   always_comb begin
      state_nxt            = state_cur;
      result.event_valid   = 1'b0;
      result.event_is_long = 1'b0;

      // long countdown is handled ahead of the debounce commit
      if (state_cur.long_armed) begin
         if (state_cur.long_left != '0) begin
            state_nxt.long_left = state_cur.long_left - 1'b1;
         end
         if (state_nxt.long_left == '0) begin
            state_nxt.long_armed = 1'b0;
            if (state_cur.held_state && !state_cur.long_done) begin
               state_nxt.long_done  = 1'b1;
               result.event_valid   = 1'b1;
               result.event_is_long = 1'b1;
            end
         end
      end

      if (level != state_cur.previous_raw) begin
         state_nxt.debounce_left  = bdlp_pkg::load_value(cfg.debounce_ticks);
         state_nxt.debounce_armed = 1'b1;
      end else if (state_cur.debounce_armed) begin
         if (state_cur.debounce_left != '0) begin
            state_nxt.debounce_left = state_cur.debounce_left - 1'b1;
         end
         if (state_nxt.debounce_left == '0) begin
            state_nxt.debounce_armed = 1'b0;
            if (level != state_cur.held_state) begin
               state_nxt.held_state = level;
               if (level) begin
                  state_nxt.long_done  = 1'b0;
                  state_nxt.long_left  = bdlp_pkg::load_value(cfg.long_press_ticks);
                  state_nxt.long_armed = 1'b1;
               end else begin
                  state_nxt.long_armed = 1'b0;
                  state_nxt.long_left  = '0;
                  if (!state_nxt.long_done && !result.event_valid) begin
                     result.event_valid   = 1'b1;
                     result.event_is_long = 1'b0;
                  end
               end
            end
         end
      end

      state_nxt.previous_raw = level;
      result.button_held     = state_nxt.held_state;
   end

endmodule

`default_nettype wire

// ===== rtl/button_debounce_long_press_core.sv =====
// Button debounce with long press detection: top level.
// Channels req_ (one pin sample per request), rsp_ (one result per request), csr_ write port.
// Path: a request accepted into the input register passes through bdlp_step; its result is loaded
//   into the output register at the next edge where that register is free, and rsp_valid then
//   stays high until the receiver takes the result with rsp_ready high.
// Throughput: one request per cycle while rsp_ready stays high. Each request's work is one pass
//   through bdlp_step, the two 16-bit countdowns and their flags updated together between the
//   input and output registers.
// Stall: when rsp_ready is low the output register holds its result; the input register still
//   takes one more request, then req_ready drops until the result is taken.
// Reset (synchronous, active high): both registers empty, state cleared, debounce_ticks = 20,
//   long_press_ticks = 1000. Register writes apply to countdowns loaded after the write.
// Result fields: event_valid/event_is_long report a short or long press; button_held is the
//   debounced level after the tick.
`default_nettype none

module button_debounce_long_press_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic                           req_pin_level,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic                           rsp_event_valid,
   output      logic                           rsp_event_is_long,
   output      logic                           rsp_button_held,
   input  wire logic                           csr_write_en,
   input  wire logic [bdlp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bdlp_pkg::CNT_W-1:0]     csr_wdata
);

`include "button_debounce_long_press_core_assert.svh"

   bdlp_pkg::cfg_type    cfg;
   bdlp_pkg::state_type  state_ff;
   bdlp_pkg::state_type  state_in;
   bdlp_pkg::result_type result_in;
   bdlp_pkg::result_type result_ff;

   logic in_valid_ff;
   logic in_level_ff;
   logic out_valid_ff;
   logic advance;

   bdlp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   bdlp_step u_step (
      .level     (in_level_ff),
      .cfg       (cfg),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (result_in)
   );

   // input register moves to output when output is empty or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_level_ff <= req_pin_level;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_valid   = result_ff.event_valid;
   assign rsp_event_is_long = result_ff.event_is_long;
   assign rsp_button_held   = result_ff.button_held;

   `BDLP_ASSERT(a_long_armed_only_held, !state_ff.long_armed || state_ff.held_state,
      "long countdown armed while button released")
   `BDLP_ASSERT(a_debounce_armed_nonzero,
      !state_ff.debounce_armed || (state_ff.debounce_left != '0),
      "debounce armed with empty countdown")
   `BDLP_ASSERT(a_short_on_release,
      !(rsp_valid && rsp_event_valid && !rsp_event_is_long) || !rsp_button_held,
      "short event reported while still held")
   `BDLP_ASSERT_NEXT(a_raw_tracks_sample, advance,
      state_ff.previous_raw == $past(in_level_ff),
      "previous raw level not taken from the processed sample")

endmodule

`default_nettype wire

// ===== tb/tb_button_debounce_long_press_core.sv =====
// Testbench for button_debounce_long_press_core: directed and random pin samples with
// self-checking of every result against a cycle-free gesture predictor.
// Depends on bdlp_pkg and the core RTL only.

module tb_button_debounce_long_press_core;
   timeunit 1ns;
   timeprecision 1ps;

   // indexes past the end of the register list, expected to be ignored
   localparam logic [bdlp_pkg::CSR_IDX_W-1:0] CSR_UNUSED_2 = 2'd2;
   localparam logic [bdlp_pkg::CSR_IDX_W-1:0] CSR_UNUSED_3 = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_pin_level = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_event_valid;
   logic                           rsp_event_is_long;
   logic                           rsp_button_held;
   logic                           csr_write_en = 1'b0;
   logic [bdlp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bdlp_pkg::CNT_W-1:0]     csr_wdata = '0;

   button_debounce_long_press_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pin_level     (req_pin_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_valid   (rsp_event_valid),
      .rsp_event_is_long (rsp_event_is_long),
      .rsp_button_held   (rsp_button_held),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // predictor state and settings
   bdlp_pkg::state_type  gest;
   bdlp_pkg::cfg_type    gest_cfg;
   bdlp_pkg::result_type expected_events[$];
   logic                 pin_queue[$];

   int   items_queued = 0;
   int   mismatches = 0;
   int   send_idle_pct = 9;
   int   recv_idle_pct = 48;
   int   stall_requests = 0;
   int   stalls_begun = 0;
   int   stall_left = 0;
   logic req_taken = 1'b0;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic logic [bdlp_pkg::CNT_W-1:0] ticks_of(
      input logic [bdlp_pkg::CNT_W-1:0] setting);
      return (setting == '0) ? bdlp_pkg::CNT_W'(1) : setting;
   endfunction

   // one tick of the gesture logic; long countdown is handled before the debounce commit
   function automatic bdlp_pkg::result_type tick_button(input logic pin);
      bdlp_pkg::result_type r;
      r = '0;
      if (gest.long_armed) begin
         if (gest.long_left != '0) gest.long_left = gest.long_left - 1'b1;
         if (gest.long_left == '0) begin
            gest.long_armed = 1'b0;
            if (gest.held_state && !gest.long_done) begin
               gest.long_done = 1'b1;
               r.event_valid = 1'b1;
               r.event_is_long = 1'b1;
            end
         end
      end
      if (pin != gest.previous_raw) begin
         gest.debounce_left = ticks_of(gest_cfg.debounce_ticks);
         gest.debounce_armed = 1'b1;
      end else if (gest.debounce_armed) begin
         if (gest.debounce_left != '0) gest.debounce_left = gest.debounce_left - 1'b1;
         if (gest.debounce_left == '0) begin
            gest.debounce_armed = 1'b0;
            if (pin != gest.held_state) begin
               gest.held_state = pin;
               if (pin) begin
                  gest.long_done = 1'b0;
                  gest.long_left = ticks_of(gest_cfg.long_press_ticks);
                  gest.long_armed = 1'b1;
               end else begin
                  gest.long_armed = 1'b0;
                  gest.long_left = '0;
                  if (!gest.long_done && !r.event_valid) begin
                     r.event_valid = 1'b1;
                     r.event_is_long = 1'b0;
                  end
               end
            end
         end
      end
      gest.previous_raw = pin;
      r.button_held = gest.held_state;
      return r;
   endfunction

   task automatic check_field(input string name, input logic want, input logic got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0b, got %0b", $time, name, want, got);
      end
   endtask

   // driver: request channel
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the request until it is taken
      end else if (pin_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
         req_pin_level <= pin_queue.pop_front();
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: random back-pressure plus a long hold-off when one is requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (stalls_begun != stall_requests) begin
         stalls_begun = stalls_begun + 1;
         stall_left = 59;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // monitor: predict on each accepted request, check each accepted result
   always @(posedge clock) begin : monitor
      bdlp_pkg::result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               mismatches++;
               $display("%0t ns: unexpected result, expected none, got %b%b%b", $time,
                        rsp_event_valid, rsp_event_is_long, rsp_button_held);
            end else begin
               want = expected_events.pop_front();
               check_field("event_valid", want.event_valid, rsp_event_valid);
               check_field("event_is_long", want.event_is_long, rsp_event_is_long);
               check_field("button_held", want.button_held, rsp_button_held);
            end
         end
         if (req_valid && req_ready) expected_events.push_back(tick_button(req_pin_level));
      end
   end

   task automatic write_reg(input logic [bdlp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bdlp_pkg::CNT_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         bdlp_pkg::CSR_DEBOUNCE_TICKS:   gest_cfg.debounce_ticks = value;
         bdlp_pkg::CSR_LONG_PRESS_TICKS: gest_cfg.long_press_ticks = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pin_queue.size() != 0 || req_valid || expected_events.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_run(input logic level, input int count);
      repeat (count) pin_queue.push_back(level);
      items_queued += count;
   endtask

   task automatic add_noise();
      repeat ($urandom_range(1, 6)) add_run(1'($urandom_range(0, 1)), 1);
   endtask

   // press, optional contact bounce at each edge; hold near long threshold if lp <= 64
   task automatic add_gesture();
      int db;
      int lp;
      int hold;
      db = int'(ticks_of(gest_cfg.debounce_ticks));
      lp = int'(ticks_of(gest_cfg.long_press_ticks));
      repeat ($urandom_range(0, 2)) begin
         add_run(1'b1, $urandom_range(1, db));
         add_run(1'b0, $urandom_range(1, db));
      end
      if (lp <= 64) begin
         case ($urandom_range(0, 3))
            0:       hold = lp - 1;
            1:       hold = lp;
            2:       hold = lp + 1;
            default: hold = $urandom_range(1, 2 * lp + 2);
         endcase
      end else begin
         hold = $urandom_range(1, 40);
      end
      if (hold <= db) hold = db + 1 + $urandom_range(0, 3);
      add_run(1'b1, hold);
      if ($urandom_range(0, 1) == 1) begin
         add_run(1'b0, $urandom_range(1, db));
         add_run(1'b1, $urandom_range(1, db));
      end
      add_run(1'b0, db + 1 + $urandom_range(0, 4));
   endtask

   task automatic fill_random(input int count);
      int goal;
      goal = items_queued + count;
      while (items_queued < goal) begin
         if ($urandom_range(0, 4) == 0) add_noise();
         else add_gesture();
      end
   endtask

   task automatic run_phase(input logic [bdlp_pkg::CNT_W-1:0] db,
                            input logic [bdlp_pkg::CNT_W-1:0] lp,
                            input int count);
      wait_drained();
      write_reg(bdlp_pkg::CSR_DEBOUNCE_TICKS, db);
      write_reg(bdlp_pkg::CSR_LONG_PRESS_TICKS, lp);
      fill_random(count);
   endtask

   initial begin
      gest = '0;
      gest_cfg.debounce_ticks = bdlp_pkg::DEBOUNCE_TICKS_RESET;
      gest_cfg.long_press_ticks = bdlp_pkg::LONG_PRESS_TICKS_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero debounce setting counts as one tick
      write_reg(bdlp_pkg::CSR_DEBOUNCE_TICKS, '0);
      write_reg(bdlp_pkg::CSR_LONG_PRESS_TICKS, 16'd3);
      write_reg(CSR_UNUSED_2, '1);
      write_reg(CSR_UNUSED_3, '0);
      add_run(1'b1, 5);   // first 1 after reset is an edge; held long enough for a long event
      add_run(1'b0, 2);
      add_run(1'b1, 2);   // short press
      add_run(1'b0, 2);
      add_run(1'b1, 1);   // edge on the expiry tick, then settle at the held level
      add_run(1'b0, 2);
      add_run(1'b1, 3);   // long expiry and release commit land on the same tick
      add_run(1'b0, 2);
      add_run(1'b1, 1);   // leave the debounce counting across the next write

      run_phase(16'd2, 16'd10, 220);
      run_phase(16'd1, 16'd1, 150);
      run_phase(bdlp_pkg::DEBOUNCE_TICKS_RESET, bdlp_pkg::LONG_PRESS_TICKS_RESET, 150);

      send_idle_pct = 48;
      recv_idle_pct = 9;
      run_phase(16'hFFFF, 16'd7, 0);
      repeat (12) add_noise();
      run_phase(16'd4, 16'd25, 260);
      run_phase(16'd0, 16'd0, 150);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(16'd1, 16'hFFFF, 100);
      run_phase(16'd3, 16'd12, 150);
      stall_requests = stall_requests + 1;
      wait_drained();
      fill_random(150);
      wait_drained();

      if (mismatches == 0 && expected_events.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
